FILE: hw/rtl/lge_pkg.sv
// Shared types and constants for the life grid generation engine.
// Depends on nothing; imported by life_grid_generation_engine_unit.
`timescale 1ns / 1ps

package lge_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 64;

  localparam int ROW_W   = $clog2(GRID_ROWS);
  localparam int COL_W   = $clog2(GRID_COLS);
  localparam int FETCH_W = $clog2(GRID_ROWS + 2);

  localparam int SURVIVE_LOW  = 2;
  localparam int SURVIVE_HIGH = 3;
  localparam int BIRTH_COUNT  = 3;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_WRITE   = 2'd0;
  localparam kind_t KIND_READ    = 2'd1;
  localparam kind_t KIND_ADVANCE = 2'd2;

  typedef logic [GRID_COLS-1:0] grid_row_t;
  typedef logic [GRID_COLS+1:0] pad_row_t;
  typedef logic [3:0]           count_t;

endpackage

FILE: hw/rtl/life_grid_generation_engine_unit.sv
// Conway B3/S23 engine over a row-organized one-bit cell grid.
// Depends on lge_pkg for grid sizes, kind codes and row types.
// A write keeps the block busy through its S_WMOD step (a write outside the grid none); a
// read holds it in S_RCAP until the output is free; its result beat is registered there
// and holds while the output stalls. An advance walks every row: one cell per cycle through
// the shared neighbor counter, plus fetch, shift and write-back per row.
// The block takes one beat at a time and is ready only when the sequencer is idle.
// Reset clears the per-row valid bits; an invalid row reads as all dead.
`timescale 1ns / 1ps

module life_grid_generation_engine_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lge_pkg::kind_t   kind,
  input  logic [4:0]       row,
  input  logic [5:0]       col,
  input  logic             alive_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             alive_out,
  output logic [4:0]       out_row,
  output logic [5:0]       out_col
);

  import lge_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WMOD  = 3'd1;
  localparam logic [2:0] S_RCAP  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_CELL  = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;

  grid_row_t           grid_mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_vld;
  grid_row_t           rdata;
  logic                rvld;
  grid_row_t           rdata_eff;

  logic                mem_re;
  logic [ROW_W-1:0]    mem_ra;
  logic                mem_we;
  logic [ROW_W-1:0]    mem_wa;
  grid_row_t           mem_wd;

  logic [4:0]          req_row;
  logic [5:0]          req_col;
  logic                req_alive;
  logic                req_inside;

  grid_row_t           prev_row;
  grid_row_t           cur_row;
  grid_row_t           nxt_row;
  grid_row_t           new_row;
  logic [FETCH_W-1:0]  fetch;
  logic [ROW_W-1:0]    crow;
  logic [COL_W-1:0]    ccol;

  pad_row_t            pad_prev;
  pad_row_t            pad_cur;
  pad_row_t            pad_nxt;
  logic [2:0]          win_prev;
  logic [2:0]          win_cur;
  logic [2:0]          win_nxt;
  count_t              ncount;
  logic                new_bit;

  logic                accept;
  logic                in_inside;
  logic                fetch_in;
  logic                out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_inside = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
  assign fetch_in  = (fetch < FETCH_W'(GRID_ROWS));
  assign out_free  = !out_valid || out_ready;
  assign rdata_eff = rvld ? rdata : '0;

  always_comb begin
    mem_re = 1'b0;
    mem_ra = row[ROW_W-1:0];
    if (state == S_IDLE) begin
      mem_re = accept && (kind == KIND_WRITE || kind == KIND_READ) && in_inside;
    end else if (state == S_FETCH) begin
      mem_re = fetch_in;
      mem_ra = fetch[ROW_W-1:0];
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = req_row[ROW_W-1:0];
    mem_wd = rdata_eff;
    if (state == S_WMOD) begin
      mem_we          = 1'b1;
      mem_wd[req_col] = req_alive;
    end else if (state == S_WB) begin
      mem_we = 1'b1;
      mem_wa = crow;
      mem_wd = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= grid_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rvld    <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rvld <= row_vld[mem_ra];
      end
    end
  end

  assign pad_prev = {1'b0, prev_row, 1'b0};
  assign pad_cur  = {1'b0, cur_row, 1'b0};
  assign pad_nxt  = {1'b0, nxt_row, 1'b0};
  assign win_prev = pad_prev[ccol +: 3];
  assign win_cur  = pad_cur[ccol +: 3];
  assign win_nxt  = pad_nxt[ccol +: 3];

  always_comb begin
    ncount = count_t'(win_prev[0]) + count_t'(win_prev[1]) + count_t'(win_prev[2])
           + count_t'(win_cur[0]) + count_t'(win_cur[2])
           + count_t'(win_nxt[0]) + count_t'(win_nxt[1]) + count_t'(win_nxt[2]);
    if (win_cur[1]) begin
      new_bit = (ncount == count_t'(SURVIVE_LOW)) || (ncount == count_t'(SURVIVE_HIGH));
    end else begin
      new_bit = (ncount == count_t'(BIRTH_COUNT));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_WRITE && in_inside) begin
            state_next = S_WMOD;
          end else if (kind == KIND_READ) begin
            state_next = S_RCAP;
          end else if (kind == KIND_ADVANCE) begin
            state_next = S_FETCH;
          end
        end
      end
      S_WMOD:  state_next = S_IDLE;
      S_RCAP:  state_next = out_free ? S_IDLE : S_RCAP;
      S_FETCH: state_next = S_SHIFT;
      S_SHIFT: state_next = (fetch == '0) ? S_FETCH : S_CELL;
      S_CELL:  state_next = (ccol == COL_W'(GRID_COLS - 1)) ? S_WB : S_CELL;
      S_WB:    state_next = (crow == ROW_W'(GRID_ROWS - 1)) ? S_IDLE : S_FETCH;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RCAP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_row    <= row;
      req_col    <= col;
      req_alive  <= alive_in;
      req_inside <= in_inside;
    end
    if (state == S_RCAP && out_free) begin
      alive_out <= req_inside ? rdata_eff[req_col] : 1'b0;
      out_row   <= req_row;
      out_col   <= req_col;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      prev_row <= '0;
      cur_row  <= '0;
      nxt_row  <= '0;
      fetch    <= '0;
      crow     <= '0;
      ccol     <= '0;
    end else begin
      if (state == S_SHIFT) begin
        prev_row <= cur_row;
        cur_row  <= nxt_row;
        nxt_row  <= fetch_in ? rdata_eff : '0;
        fetch    <= fetch + FETCH_W'(1);
        ccol     <= '0;
      end
      if (state == S_CELL) begin
        new_row[ccol] <= new_bit;
        ccol          <= ccol + COL_W'(1);
      end
      if (state == S_WB) begin
        crow <= crow + ROW_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_out_from_rcap: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RCAP)
    else $error("result beat raised outside the read capture step");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_WMOD || state == S_WB))
    else $error("grid memory written outside a write or write-back step");

  a_last_row_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && crow == ROW_W'(GRID_ROWS - 1)) |=> state == S_IDLE)
    else $error("advance did not finish after the last row");

  a_cell_has_rows: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |-> fetch >= FETCH_W'(2))
    else $error("cell sweep started before the row window was filled");
`endif

endmodule
